>>> rtl/core/fwui_pkg.sv
// ----------------------------------------------------------------------------
// fwui_pkg
// Shared types and constants of the waiting line with urgent insertion.
// ----------------------------------------------------------------------------
package fwui_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 16;
  localparam int IN_ID_W      = 16;
  localparam int OUT_ID_W     = 16;

  typedef enum logic [1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_URGENT  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_LIST    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_URG_MOVE,
    S_URG_SET,
    S_RELEASE,
    S_LIST_RD,
    S_LIST_OUT
  } state_t;

  typedef enum logic {
    RD_HEAD,
    RD_WALK
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_TAIL,
    WR_HEAD,
    WR_HEAD_M1
  } wr_sel_t;

  typedef struct packed {
    logic    latch_in;
    logic    mem_rd;
    rd_sel_t rd_sel;
    logic    mem_wr;
    wr_sel_t wr_sel;
    logic    wr_from_mem;
    logic    head_inc;
    logic    head_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    walk_load;
    logic    walk_adv;
    logic    out_load;
    status_t out_st;
    logic    out_from_mem;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_zero;
    logic  cnt_full;
    logic  remain_one;
    logic  out_free;
  } sts_t;

endpackage

>>> rtl/core/fwui_ram.sv
// ----------------------------------------------------------------------------
// fwui_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwui_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/fwui_ctrl.sv
// ----------------------------------------------------------------------------
// fwui_ctrl
// Sequencer: decodes each request and steps the datapath through it.
// ----------------------------------------------------------------------------
module fwui_ctrl
  import fwui_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.kind)
          KIND_NORMAL: begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            state_nxt    = S_IDLE;
            if (sts.cnt_full) begin
              cmd.out_st = STAT_FULL;
            end else begin
              cmd.out_st  = STAT_OK;
              cmd.mem_wr  = 1'b1;
              cmd.wr_sel  = WR_TAIL;
              cmd.cnt_inc = 1'b1;
            end
          end
          KIND_URGENT: begin
            priority if (sts.cnt_full) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              cmd.out_st   = STAT_FULL;
              state_nxt    = S_IDLE;
            end else if (sts.cnt_zero) begin
              cmd.mem_wr   = 1'b1;
              cmd.wr_sel   = WR_HEAD;
              cmd.cnt_inc  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              cmd.out_st   = STAT_OK;
              state_nxt    = S_IDLE;
            end else begin
              cmd.mem_rd = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_nxt  = S_URG_MOVE;
            end
          end
          KIND_RELEASE: begin
            if (sts.cnt_zero) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              cmd.out_st   = STAT_EMPTY;
              state_nxt    = S_IDLE;
            end else begin
              cmd.mem_rd = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_nxt  = S_RELEASE;
            end
          end
          KIND_LIST: begin
            if (sts.cnt_zero) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              cmd.out_st   = STAT_EMPTY;
              state_nxt    = S_IDLE;
            end else begin
              cmd.walk_load = 1'b1;
              state_nxt     = S_LIST_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_URG_MOVE: begin
        cmd.mem_wr      = 1'b1;
        cmd.wr_sel      = WR_HEAD_M1;
        cmd.wr_from_mem = 1'b1;
        state_nxt       = S_URG_SET;
      end
      S_URG_SET: begin
        cmd.mem_wr   = 1'b1;
        cmd.wr_sel   = WR_HEAD;
        cmd.head_dec = 1'b1;
        cmd.cnt_inc  = 1'b1;
        cmd.out_load = 1'b1;
        cmd.out_last = 1'b1;
        cmd.out_st   = STAT_OK;
        state_nxt    = S_IDLE;
      end
      S_RELEASE: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_mem = 1'b1;
        cmd.out_last     = 1'b1;
        cmd.out_st       = STAT_OK;
        cmd.head_inc     = 1'b1;
        cmd.cnt_dec      = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_LIST_RD: begin
        if (sts.out_free) begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RD_WALK;
          state_nxt  = S_LIST_OUT;
        end
      end
      S_LIST_OUT: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_mem = 1'b1;
        cmd.out_last     = sts.remain_one;
        cmd.out_st       = STAT_OK;
        cmd.walk_adv     = 1'b1;
        state_nxt        = sts.remain_one ? S_IDLE : S_LIST_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/fwui_dp.sv
// ----------------------------------------------------------------------------
// fwui_dp
// Datapath: ring store of identifiers, head and count, list walker and
// result word register.
// ----------------------------------------------------------------------------
module fwui_dp
  import fwui_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kind_t               in_kind,
  input  logic [IN_ID_W-1:0]  in_patient_id,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [OUT_ID_W-1:0] out_entry_id,
  output status_t             out_status,
  output logic                out_last
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_X  = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [PW-1:0]       head_r, walk_r;
  logic [CW-1:0]       cnt_r, remain_r;
  kind_t               kind_r;
  logic [ID_WIDTH-1:0] id_r;
  logic                out_valid_r;
  logic [OUT_ID_W-1:0] out_id_r;
  status_t             out_st_r;
  logic                out_last_r;

  logic [PW-1:0]                head_p1, head_m1, walk_p1, tail_idx;
  logic [PW:0]                  tail_sum, tail_wrap;
  logic [PW-1:0]                wr_addr, rd_addr;
  logic [ID_WIDTH-1:0]          wr_data, rd_data;
  logic [ID_WIDTH+IN_ID_W-1:0]  id_ext;
  logic [ID_WIDTH+OUT_ID_W-1:0] rd_ext;

  assign head_p1   = (head_r == LAST_IDX) ? '0 : head_r + PW'(1);
  assign head_m1   = (head_r == '0) ? LAST_IDX : head_r - PW'(1);
  assign walk_p1   = (walk_r == LAST_IDX) ? '0 : walk_r + PW'(1);
  assign tail_sum  = {1'b0, head_r} + (PW + 1)'(cnt_r);
  assign tail_wrap = (tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum;
  assign tail_idx  = tail_wrap[PW-1:0];

  assign id_ext = {{ID_WIDTH{1'b0}}, in_patient_id};
  assign rd_ext = {{OUT_ID_W{1'b0}}, rd_data};

  always_comb begin
    unique case (cmd.wr_sel)
      WR_TAIL:    wr_addr = tail_idx;
      WR_HEAD:    wr_addr = head_r;
      WR_HEAD_M1: wr_addr = head_m1;
      default:    wr_addr = head_r;
    endcase
  end

  assign wr_data = cmd.wr_from_mem ? rd_data : id_r;
  assign rd_addr = (cmd.rd_sel == RD_WALK) ? walk_r : head_r;

  fwui_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.mem_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.mem_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      walk_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.head_inc) begin
        head_r <= head_p1;
      end else if (cmd.head_dec) begin
        head_r <= head_m1;
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.walk_load) begin
        walk_r   <= head_r;
        remain_r <= cnt_r;
      end else if (cmd.walk_adv) begin
        walk_r   <= walk_p1;
        remain_r <= remain_r - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      id_r   <= id_ext[ID_WIDTH-1:0];
    end
    if (cmd.out_load) begin
      out_id_r   <= cmd.out_from_mem ? rd_ext[OUT_ID_W-1:0] : '0;
      out_st_r   <= cmd.out_st;
      out_last_r <= cmd.out_last;
    end
  end

  assign sts.kind       = kind_r;
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.cnt_full   = (cnt_r == DEPTH_C);
  assign sts.remain_one = (remain_r == CW'(1));
  assign sts.out_free   = !out_valid_r;

  assign out_valid    = out_valid_r;
  assign out_entry_id = out_id_r;
  assign out_status   = out_st_r;
  assign out_last     = out_last_r;

endmodule

>>> rtl/core/fifo_with_urgent_insert.sv
// ----------------------------------------------------------------------------
// fifo_with_urgent_insert
// Ordered waiting line of identifiers with urgent insertion behind the head.
// ----------------------------------------------------------------------------
// The line lives in a ring of DEPTH entries in a single-port-read RAM with
// registered read data; a head pointer and a count describe it. Requests are
// handled one at a time by a sequencer, and a request is taken only while the
// output register is empty. A normal arrival, a refused arrival and any
// request on an empty line pass through accept and decode, after which the
// result word leaves the output register. A release also waits for the RAM
// read of the head. An urgent arrival into a non-empty line reads the head,
// copies it one slot back, and writes the new entry into its old slot. A list
// costs each entry one RAM read, one load of the result word and the wait for
// that word to leave. A result word that waits on the result side holds up
// the sequencer. The next request is taken in the cycle after the last result
// word is taken.
// ----------------------------------------------------------------------------
module fifo_with_urgent_insert
  import fwui_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] patient_id
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] entry_id
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  cmd_t    cmd;
  sts_t    sts;
  status_t out_st;

  fwui_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fwui_dp #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (kind_t'(in_tuser)),
    .in_patient_id (in_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_entry_id  (out_tdata),
    .out_status    (out_st),
    .out_last      (out_tlast)
  );

  assign out_tuser = out_st;

  a_ready_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a result word is pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("sequencer took a request while busy");

  a_zero_id_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != STAT_OK)) |-> (out_tdata == '0) && out_tlast)
    else $error("non-ok result carries an id or is not last");

endmodule

>>> dv/fwui_line_checker.sv
// ----------------------------------------------------------------------------
// fwui_line_checker
// Predicts and checks every result word of the waiting line with urgent insert.
// ----------------------------------------------------------------------------
// Watches the request and result streams. Each accepted request is applied to
// a private copy of the line. The result words that the request should produce
// are queued. Each accepted result word is compared field by field with the
// oldest queued word. Failures and the number of words still awaited are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module fwui_line_checker
  import fwui_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] patient_id
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] entry_id
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [OUT_ID_W-1:0] entry_id;
    status_t             status;
    logic                last;
  } line_word_t;

  logic [ID_WIDTH_DEF-1:0] line_ids[$];
  line_word_t              awaited_words[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic predict_line_words(input kind_t kind, input logic [ID_WIDTH_DEF-1:0] id);
    line_word_t w;
    w = '{entry_id: '0, status: STAT_OK, last: 1'b1};
    case (kind)
      KIND_NORMAL, KIND_URGENT: begin
        if (line_ids.size() >= DEPTH_DEF) w.status = STAT_FULL;
        else if (kind == KIND_NORMAL || line_ids.size() == 0) line_ids.push_back(id);
        else line_ids.insert(1, id);
        awaited_words.push_back(w);
      end
      KIND_RELEASE: begin
        if (line_ids.size() == 0) w.status = STAT_EMPTY;
        else w.entry_id = OUT_ID_W'(line_ids.pop_front());
        awaited_words.push_back(w);
      end
      default: begin
        if (line_ids.size() == 0) begin
          w.status = STAT_EMPTY;
          awaited_words.push_back(w);
        end else begin
          foreach (line_ids[i]) begin
            w.entry_id = OUT_ID_W'(line_ids[i]);
            w.last     = (i == line_ids.size() - 1);
            awaited_words.push_back(w);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    line_word_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word id %h status %0d last %b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          want = awaited_words.pop_front();
          if (out_tdata !== want.entry_id)
            report_mismatch($sformatf("entry_id %h, want %h", out_tdata, want.entry_id));
          if (out_tuser !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_tlast, want.last));
        end
      end
      if (in_tvalid && in_tready)
        predict_line_words(kind_t'(in_tuser), in_tdata[ID_WIDTH_DEF-1:0]);
    end
    pending_count <= awaited_words.size();
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the waiting line with urgent insertion.
// ----------------------------------------------------------------------------
// A directed opening covers empty release and list, urgent entry into an empty
// line, a full line refusing both arrival kinds and a full list. Random
// phases then lean towards filling or draining the line, so that it swings
// between empty and full. The sender works in bursts and the receiver stalls
// in changing patterns. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import fwui_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_TRICKLE
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = KIND_NORMAL;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [15:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         out_tlast;

  int          fail_count;
  int          pending_count;
  int unsigned burst_left = 1;
  int unsigned ready_tick = 0;
  rx_mode_t    ready_mode = RX_OPEN;

  always #10 clk = ~clk;

  fifo_with_urgent_insert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  fwui_line_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // stall pattern of the receiver
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 96 == 0) ready_mode <= rx_mode_t'($urandom_range(3));
    case (ready_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(1));
      RX_MOSTLY: out_tready <= ($urandom_range(3) != 0);
      default:   out_tready <= (ready_tick % 8 == 0);
    endcase
  end

  task automatic push_request(input kind_t kind, input logic [15:0] id);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= id;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
  endtask

  task automatic drain_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned arrival_pct;
    int unsigned pick;
    logic [15:0] id;
    kind_t       kind;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request(KIND_RELEASE, 16'hFFFF);
    push_request(KIND_LIST, 16'hFFFF);
    push_request(KIND_URGENT, 16'hFFFF);
    push_request(KIND_NORMAL, 16'h0000);
    push_request(KIND_URGENT, 16'h8001);
    push_request(KIND_LIST, 16'h0000);
    for (int i = 0; i < 13; i++) push_request(KIND_NORMAL, 16'(i * 16'h1357 + 1));
    push_request(KIND_NORMAL, 16'h5A5A);
    push_request(KIND_URGENT, 16'hA5A5);
    push_request(KIND_LIST, 16'h0000);
    push_request(KIND_RELEASE, 16'h0000);
    drain_wait();

    arrival_pct = 50;
    for (int n = 0; n < 480; n++) begin
      if (n % 40 == 0) arrival_pct = $urandom_range(80, 15);
      if (n == 240) drain_wait();
      pick = $urandom_range(99);
      if (pick < arrival_pct) kind = $urandom_range(1) ? KIND_URGENT : KIND_NORMAL;
      else if (pick < 90) kind = KIND_RELEASE;
      else kind = KIND_LIST;
      id = 16'($urandom);
      case ($urandom_range(7))
        0: id = 16'h0000;
        1: id = 16'hFFFF;
        default: ;
      endcase
      push_request(kind, id);
    end

    drain_wait();
    repeat (24) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fwui_pkg.sv
rtl/core/fwui_ram.sv
rtl/core/fwui_ctrl.sv
rtl/core/fwui_dp.sv
rtl/core/fifo_with_urgent_insert.sv
dv/fwui_line_checker.sv
dv/tb.sv
